// ----- src/psm_pkg.sv -----
// psm_pkg: types, constants and arithmetic helpers shared by the point
// self-mask filter. No dependencies.
package psm_pkg;

    localparam int XFORM_WORDS = 24;
    localparam int BOX_WORDS   = 8;
    localparam int CYL_WORDS   = 6;

    localparam logic [1:0] K_POINT = 2'd0;
    localparam logic [1:0] K_XFORM = 2'd1;
    localparam logic [1:0] K_BOX   = 2'd2;
    localparam logic [1:0] K_CYL   = 2'd3;

    localparam logic [63:0] SAT63    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] SQ_LIMIT = 32'd3037000499;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         word_index;
        logic [2:0]         entry_index;
        logic [31:0]        word_value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               point_valid;
        logic               last_point;
    } psm_item_t;

    function automatic logic signed [32:0] sx33(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [35:0] sx36(input logic signed [32:0] v);
        return {{3{v[32]}}, v};
    endfunction

    function automatic logic signed [37:0] sx38(input logic [31:0] v);
        return {{6{v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic ovf;
        ovf = (v[35:31] != 5'b00000) && (v[35:31] != 5'b11111);
        if (!ovf) begin
            return v[31:0];
        end
        return v[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // Q16.16 x Q2.30 product rounded back to Q16.16 (floor of p + 2^29)
    function automatic logic signed [35:0] mul_rnd(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd536870912;
        return t[65:30];
    endfunction

    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = v[32] ? -v : v;
        return n[31:0];
    endfunction

    function automatic logic [63:0] sq_term(input logic [31:0] a,
                                            input logic signed [65:0] p);
        return (a > SQ_LIMIT) ? SAT63 : p[63:0];
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, SAT63}) ? SAT63 : s[63:0];
    endfunction

    function automatic logic signed [37:0] twice_abs(input logic signed [35:0] v);
        logic signed [37:0] e;
        e = {{2{v[35]}}, v};
        if (e < 0) begin
            e = -e;
        end
        return e <<< 1;
    endfunction

endpackage

// ----- src/point_self_mask_filter_unit.sv -----
// point_self_mask_filter_unit: top level of the point self-mask filter.
// Depends on psm_pkg, psm_front, psm_queue, psm_back.
//
//   port group   | direction | handshake          | carries
//   s_*          | in        | s_valid / s_ready  | point or table-write item
//   m_*          | out       | m_valid / m_ready  | keep flag and cloud statistics
//   cfg_*        | in        | cfg_we             | box_count, cylinder_count
//
// A point's back-end work grows with the boxes and cylinders it is tested
// against, paced by one shared 33x33 multiplier and by one-word-per-cycle
// reads of the box and cylinder memories. Table writes are done as the
// item is taken from the queue. A two-entry queue lets the input side accept
// up to two items while the back end works or the result register is stalled.
// aresetn is synchronous, active low; tables are undefined until written.
module point_self_mask_filter_unit import psm_pkg::*; #(
    parameter int MAX_BOXES     = 8,
    parameter int MAX_CYLINDERS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [3:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [4:0]         s_word_index,
    input  logic [2:0]         s_entry_index,
    input  logic signed [31:0] s_word_value,
    input  logic signed [31:0] s_x,
    input  logic signed [31:0] s_y,
    input  logic signed [31:0] s_z,
    input  logic               s_point_valid,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_keep,
    output logic               m_is_last,
    output logic [31:0]        m_input_count,
    output logic [31:0]        m_removed_count,
    output logic [62:0]        m_nearest_before_sq,
    output logic               m_have_nearest_before,
    output logic [62:0]        m_nearest_after_sq,
    output logic               m_have_nearest_after
);

    logic      push_valid, push_ready, q_valid, q_ready;
    psm_item_t push_item, q_item;

    psm_front #(
        .MAX_BOXES     (MAX_BOXES),
        .MAX_CYLINDERS (MAX_CYLINDERS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_word_index  (s_word_index),
        .s_entry_index (s_entry_index),
        .s_word_value  (s_word_value),
        .s_x           (s_x),
        .s_y           (s_y),
        .s_z           (s_z),
        .s_point_valid (s_point_valid),
        .s_last_point  (s_last_point),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    psm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    psm_back #(
        .MAX_BOXES     (MAX_BOXES),
        .MAX_CYLINDERS (MAX_CYLINDERS)
    ) u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .q_valid               (q_valid),
        .q_ready               (q_ready),
        .q_item                (q_item),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_keep                (m_keep),
        .m_is_last             (m_is_last),
        .m_input_count         (m_input_count),
        .m_removed_count       (m_removed_count),
        .m_nearest_before_sq   (m_nearest_before_sq),
        .m_have_nearest_before (m_have_nearest_before),
        .m_nearest_after_sq    (m_nearest_after_sq),
        .m_have_nearest_after  (m_have_nearest_after)
    );

endmodule

// ----- src/psm_front.sv -----
// psm_front: accepts input items, classifies them and drops writes with
// out-of-range addresses. Depends on psm_pkg.
module psm_front import psm_pkg::*; #(
    parameter int MAX_BOXES     = 8,
    parameter int MAX_CYLINDERS = 8
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [4:0]        s_word_index,
    input  logic [2:0]        s_entry_index,
    input  logic [31:0]       s_word_value,
    input  logic signed [31:0] s_x,
    input  logic signed [31:0] s_y,
    input  logic signed [31:0] s_z,
    input  logic              s_point_valid,
    input  logic              s_last_point,
    output logic              push_valid,
    input  logic              push_ready,
    output psm_item_t         push_item
);

    logic useful;

    always_comb begin
        unique case (s_op)
            K_POINT: useful = 1'b1;
            K_XFORM: useful = 32'(s_word_index) < XFORM_WORDS;
            K_BOX:   useful = (32'(s_word_index) < BOX_WORDS)
                              && (32'(s_entry_index) < MAX_BOXES);
            K_CYL:   useful = (32'(s_word_index) < CYL_WORDS)
                              && (32'(s_entry_index) < MAX_CYLINDERS);
            default: useful = 1'b0;
        endcase
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid && useful;

    always_comb begin
        push_item.kind        = s_op;
        push_item.word_index  = s_word_index;
        push_item.entry_index = s_entry_index;
        push_item.word_value  = s_word_value;
        push_item.x           = s_x;
        push_item.y           = s_y;
        push_item.z           = s_z;
        push_item.point_valid = s_point_valid;
        push_item.last_point  = s_last_point;
    end

endmodule

// ----- src/psm_queue.sv -----
// psm_queue: two-entry item queue between front and back end.
// Depends on psm_pkg.
module psm_queue import psm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  psm_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output psm_item_t out_item
);

    psm_item_t  slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = slot_reg[rptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

endmodule

// ----- src/psm_back.sv -----
// psm_back: executes queued items: table writes, frame transforms, volume
// tests and cloud statistics on one shared multiplier. Depends on psm_pkg.
module psm_back import psm_pkg::*; #(
    parameter int MAX_BOXES     = 8,
    parameter int MAX_CYLINDERS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        q_valid,
    output logic        q_ready,
    input  psm_item_t   q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_keep,
    output logic        m_is_last,
    output logic [31:0] m_input_count,
    output logic [31:0] m_removed_count,
    output logic [62:0] m_nearest_before_sq,
    output logic        m_have_nearest_before,
    output logic [62:0] m_nearest_after_sq,
    output logic        m_have_nearest_after
);

    localparam int BDEPTH = MAX_BOXES * BOX_WORDS;
    localparam int CDEPTH = MAX_CYLINDERS * CYL_WORDS;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int CAW    = $clog2(CDEPTH);

    localparam logic [0:0] R_BOX_COUNT = 1'd0;
    localparam logic [0:0] R_CYL_COUNT = 1'd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_REL   = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_ROT   = 4'd3;
    localparam logic [3:0] S_SUB   = 4'd4;
    localparam logic [3:0] S_BSEL  = 4'd5;
    localparam logic [3:0] S_BLOAD = 4'd6;
    localparam logic [3:0] S_BPREP = 4'd7;
    localparam logic [3:0] S_BMUL  = 4'd8;
    localparam logic [3:0] S_BTEST = 4'd9;
    localparam logic [3:0] S_CSEL  = 4'd10;
    localparam logic [3:0] S_CLOAD = 4'd11;
    localparam logic [3:0] S_CPREP = 4'd12;
    localparam logic [3:0] S_CMUL  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] state_reg;
    logic       ph_reg;
    logic [1:0] i_reg, j_reg;
    logic [3:0] k_reg, w_reg;
    logic       rot2_reg;
    logic       keep_reg, pval_reg, plast_reg;

    logic [3:0] nbox_reg, ncyl_reg, nb, nc;

    logic [31:0]        xform_reg [XFORM_WORDS];
    logic [31:0]        box_mem   [BDEPTH];
    logic [31:0]        cyl_mem   [CDEPTH];
    logic [31:0]        box_rd_reg, cyl_rd_reg;
    logic [BAW-1:0]     box_raddr, box_waddr;
    logic [CAW-1:0]     cyl_raddr, cyl_waddr;

    logic [31:0]        p_reg   [3];
    logic signed [32:0] rel_reg [3];
    logic [31:0]        vec_reg [3];
    logic [31:0]        res_reg [3];
    logic [31:0]        ent_reg [BOX_WORDS];
    logic [63:0]        d2_reg, csum_reg;
    logic signed [35:0] acc_reg, lx_reg, ly_reg;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic signed [65:0] prod_reg;

    logic [31:0] seen_reg, removed_reg;
    logic [63:0] minb_reg, mina_reg;
    logic [1:0]  flag_reg;

    logic               pop;
    logic [4:0]         xf_idx;
    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        sq_op;
    logic signed [35:0] rnd, rot_sum;
    logic               box_in, cyl_in, out_free;

    logic [31:0] seen1, rem1;
    logic [63:0] minb1, mina1;
    logic [1:0]  flag1;

    assign nb = (32'(nbox_reg) > MAX_BOXES) ? 4'(MAX_BOXES) : nbox_reg;
    assign nc = (32'(ncyl_reg) > MAX_CYLINDERS) ? 4'(MAX_CYLINDERS) : ncyl_reg;

    assign q_ready  = (state_reg == S_IDLE);
    assign pop      = q_valid && q_ready;
    assign out_free = !m_valid || m_ready;

    assign xf_idx    = (rot2_reg ? 5'd15 : 5'd3) + 5'(j_reg) * 5'd3 + 5'(i_reg);
    assign box_waddr = BAW'({q_item.entry_index, q_item.word_index[2:0]});
    assign cyl_waddr = CAW'(q_item.entry_index) * CAW'(CYL_WORDS)
                       + CAW'(q_item.word_index);
    assign box_raddr = BAW'({k_reg, w_reg[2:0]});
    assign cyl_raddr = CAW'(k_reg) * CAW'(CYL_WORDS) + CAW'(w_reg);

    // shared multiplier operand select
    always_comb begin
        sq_op = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ: begin
                sq_op = abs33(rel_reg[i_reg]);
                mul_a = {1'b0, sq_op};
                mul_b = {1'b0, sq_op};
            end
            S_ROT: begin
                mul_a = sx33(xform_reg[xf_idx]);
                mul_b = sx33(vec_reg[j_reg]);
            end
            S_BMUL: begin
                mul_a = sx33(i_reg[0] ? ent_reg[7] : ent_reg[6]);
                unique case (i_reg)
                    2'd0, 2'd3: mul_b = dx_reg;
                    default:    mul_b = dy_reg;
                endcase
            end
            S_CMUL: begin
                unique case (i_reg)
                    2'd0: sq_op = abs33(dx_reg);
                    2'd1: sq_op = abs33(dy_reg);
                    default: sq_op = '0;
                endcase
                if (i_reg == 2'd2) begin
                    mul_a = sx33(ent_reg[3]);
                    mul_b = sx33(ent_reg[3]);
                end else begin
                    mul_a = {1'b0, sq_op};
                    mul_b = {1'b0, sq_op};
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd     = mul_rnd(prod_reg);
    assign rot_sum = acc_reg + rnd;

    assign box_in = (twice_abs(lx_reg) <= sx38(ent_reg[3]))
                 && (twice_abs(ly_reg) <= sx38(ent_reg[4]))
                 && (twice_abs(sx36(dz_reg)) <= sx38(ent_reg[5]));
    assign cyl_in = (csum_reg <= prod_reg[63:0])
                 && (dz_reg >= sx33(ent_reg[4])) && (dz_reg <= sx33(ent_reg[5]));

    // statistics update for the point being finished
    always_comb begin
        seen1 = (seen_reg == '1) ? seen_reg : seen_reg + 32'd1;
        rem1  = (!keep_reg && removed_reg != '1) ? removed_reg + 32'd1 : removed_reg;
        minb1 = (pval_reg && d2_reg < minb_reg) ? d2_reg : minb_reg;
        mina1 = (pval_reg && keep_reg && d2_reg < mina_reg) ? d2_reg : mina_reg;
        flag1 = flag_reg | {pval_reg && keep_reg, pval_reg};
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        box_rd_reg <= box_mem[box_raddr];
        cyl_rd_reg <= cyl_mem[cyl_raddr];
        if (pop && q_item.kind == K_BOX) begin
            box_mem[box_waddr] <= q_item.word_value;
        end
        if (pop && q_item.kind == K_CYL) begin
            cyl_mem[cyl_waddr] <= q_item.word_value;
        end
        if (pop && q_item.kind == K_XFORM) begin
            xform_reg[q_item.word_index] <= q_item.word_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ph_reg      <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            w_reg       <= '0;
            rot2_reg    <= 1'b0;
            m_valid     <= 1'b0;
            nbox_reg    <= '0;
            ncyl_reg    <= '0;
            seen_reg    <= '0;
            removed_reg <= '0;
            minb_reg    <= '1;
            mina_reg    <= '1;
            flag_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    R_BOX_COUNT: nbox_reg <= cfg_wdata;
                    R_CYL_COUNT: ncyl_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready && state_reg != S_DONE) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (pop && q_item.kind == K_POINT) begin
                        p_reg[0]  <= q_item.x;
                        p_reg[1]  <= q_item.y;
                        p_reg[2]  <= q_item.z;
                        pval_reg  <= q_item.point_valid;
                        plast_reg <= q_item.last_point;
                        keep_reg  <= 1'b1;
                        state_reg <= q_item.point_valid ? S_REL : S_DONE;
                    end
                end
                S_REL: begin
                    for (int n = 0; n < 3; n++) begin
                        rel_reg[n] <= sx33(p_reg[n]) - sx33(xform_reg[n]);
                        vec_reg[n] <= sat32(sx36(sx33(p_reg[n]) - sx33(xform_reg[n])));
                    end
                    d2_reg    <= '0;
                    i_reg     <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        d2_reg <= add_sat(d2_reg, sq_term(sq_op, prod_reg));
                        if (i_reg == 2'd2) begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            acc_reg   <= '0;
                            rot2_reg  <= 1'b0;
                            state_reg <= S_ROT;
                        end else begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end
                end
                S_ROT: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (j_reg == 2'd2) begin
                            res_reg[i_reg] <= sat32(rot_sum);
                            acc_reg        <= '0;
                            j_reg          <= '0;
                            if (i_reg == 2'd2) begin
                                i_reg     <= '0;
                                k_reg     <= '0;
                                state_reg <= rot2_reg ? S_BSEL : S_SUB;
                            end else begin
                                i_reg <= i_reg + 2'd1;
                            end
                        end else begin
                            acc_reg <= rot_sum;
                            j_reg   <= j_reg + 2'd1;
                        end
                    end
                end
                S_SUB: begin
                    for (int n = 0; n < 3; n++) begin
                        vec_reg[n] <= sat32(sx36(sx33(res_reg[n])
                                      - sx33(xform_reg[12 + n])));
                    end
                    rot2_reg  <= 1'b1;
                    ph_reg    <= 1'b0;
                    state_reg <= S_ROT;
                end
                S_BSEL: begin
                    w_reg <= '0;
                    if (k_reg < nb) begin
                        state_reg <= S_BLOAD;
                    end else begin
                        k_reg     <= '0;
                        state_reg <= S_CSEL;
                    end
                end
                S_BLOAD: begin
                    if (w_reg != 4'd0) begin
                        ent_reg[3'(w_reg - 4'd1)] <= box_rd_reg;
                    end
                    if (32'(w_reg) == BOX_WORDS) begin
                        state_reg <= S_BPREP;
                    end else begin
                        w_reg <= w_reg + 4'd1;
                    end
                end
                S_BPREP: begin
                    dx_reg <= sx33(sat32(sx36(sx33(res_reg[0]) - sx33(ent_reg[0]))));
                    dy_reg <= sx33(sat32(sx36(sx33(res_reg[1]) - sx33(ent_reg[1]))));
                    dz_reg <= sx33(res_reg[2]) - sx33(ent_reg[2]);
                    i_reg     <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= S_BMUL;
                end
                S_BMUL: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        unique case (i_reg)
                            2'd0: lx_reg <= rnd;
                            2'd1: lx_reg <= lx_reg + rnd;
                            2'd2: ly_reg <= rnd;
                            default: ly_reg <= ly_reg - rnd;
                        endcase
                        i_reg <= i_reg + 2'd1;
                        if (i_reg == 2'd3) begin
                            state_reg <= S_BTEST;
                        end
                    end
                end
                S_BTEST: begin
                    if (box_in) begin
                        keep_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end else begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_BSEL;
                    end
                end
                S_CSEL: begin
                    w_reg <= '0;
                    state_reg <= (k_reg < nc) ? S_CLOAD : S_DONE;
                end
                S_CLOAD: begin
                    if (w_reg != 4'd0) begin
                        ent_reg[3'(w_reg - 4'd1)] <= cyl_rd_reg;
                    end
                    if (32'(w_reg) == CYL_WORDS) begin
                        state_reg <= S_CPREP;
                    end else begin
                        w_reg <= w_reg + 4'd1;
                    end
                end
                S_CPREP: begin
                    dx_reg <= sx33(res_reg[0]) - sx33(ent_reg[0]);
                    dy_reg <= sx33(res_reg[1]) - sx33(ent_reg[1]);
                    dz_reg <= sx33(res_reg[2]) - sx33(ent_reg[2]);
                    i_reg     <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= S_CMUL;
                end
                S_CMUL: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        i_reg <= i_reg + 2'd1;
                        unique case (i_reg)
                            2'd0: csum_reg <= sq_term(sq_op, prod_reg);
                            2'd1: csum_reg <= add_sat(csum_reg, sq_term(sq_op, prod_reg));
                            default: begin
                                if (cyl_in) begin
                                    keep_reg  <= 1'b0;
                                    state_reg <= S_DONE;
                                end else begin
                                    k_reg     <= k_reg + 4'd1;
                                    state_reg <= S_CSEL;
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid   <= 1'b1;
                        m_keep    <= keep_reg;
                        m_is_last <= plast_reg;
                        if (plast_reg) begin
                            m_input_count         <= seen1;
                            m_removed_count       <= rem1;
                            m_nearest_before_sq   <= flag1[0] ? minb1[62:0] : '0;
                            m_have_nearest_before <= flag1[0];
                            m_nearest_after_sq    <= flag1[1] ? mina1[62:0] : '0;
                            m_have_nearest_after  <= flag1[1];
                            seen_reg    <= '0;
                            removed_reg <= '0;
                            minb_reg    <= '1;
                            mina_reg    <= '1;
                            flag_reg    <= '0;
                        end else begin
                            m_input_count         <= '0;
                            m_removed_count       <= '0;
                            m_nearest_before_sq   <= '0;
                            m_have_nearest_before <= 1'b0;
                            m_nearest_after_sq    <= '0;
                            m_have_nearest_after  <= 1'b0;
                            seen_reg    <= seen1;
                            removed_reg <= rem1;
                            minb_reg    <= minb1;
                            mina_reg    <= mina1;
                            flag_reg    <= flag1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_stats_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_last |-> m_input_count == 0 && m_removed_count == 0
            && !m_have_nearest_before && !m_have_nearest_after)
        else $error("statistics on a non-last transfer");

    a_removed_le_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_last |-> m_removed_count <= m_input_count)
        else $error("removed count exceeds input count");

    a_after_needs_before: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_have_nearest_after |-> m_have_nearest_before
            && m_nearest_before_sq <= m_nearest_after_sq)
        else $error("nearest after removal inconsistent");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !pop)
        else $error("queue popped while busy");

    a_dropped_implies_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !keep_reg |-> pval_reg)
        else $error("untested point dropped");

endmodule
